// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the TDS meter blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TDSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TDSM_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TDSM_ASSERT(lbl, clk, rst_n, prop)
`define TDSM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/tdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// TDS meter package
// Types, constants and register codes shared by the TDS meter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tdsm_pkg;
    localparam int SAMPLES_DEF = 32;
    localparam int CODE_W      = 12;
    localparam int TEMP_W      = 12;
    localparam int TDS_W       = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_BITS    = 20;
    localparam int K_W         = 5;

    localparam logic [15:0] SAMPLE_IV_RST  = 16'd40;
    localparam logic [15:0] COMPUTE_IV_RST = 16'd800;
    localparam logic [12:0] REF_MV_RST     = 13'd5000;
    localparam logic [12:0] FULL_SCALE_RST = 13'd1024;

    localparam logic [25:0] C3_Q16  = 26'd8743813;
    localparam logic [25:0] C2_Q16  = 26'd16768041;
    localparam logic [25:0] C1_Q16  = 26'd56189911;
    localparam logic [TDS_W-1:0] TDS_MAX = 20'hFFFFF;
    localparam logic signed [12:0] TEMP_OFFSET = 13'sd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_IV  = 2'd0,
        REG_COMPUTE_IV = 2'd1,
        REG_REF_MV     = 2'd2,
        REG_FULL_SCALE = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_DRAIN, S_MED, S_NUM, S_DEN, S_DIVI, S_DIV,
        S_V2, S_V3, S_T3, S_T2, S_T1, S_SUM, S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        MUL_NUM, MUL_DEN, MUL_VV, MUL_V2V, MUL_C3, MUL_C2, MUL_C1
    } t_mul_sel;

    typedef struct packed {
        logic           tick;
        logic           cmp_en;
        logic           cmp_first;
        logic           cmp_last;
        logic           med_en;
        logic           mul_en;
        t_mul_sel       mul_sel;
        logic           div_init;
        logic           div_step;
        logic [K_W-1:0] div_bit;
        logic           sum_en;
        logic           load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic compute_fire;
        logic sat;
        logic out_busy;
    } t_dp_stat;
endpackage
`default_nettype wire

// ----- hdl/tdsm_if.sv -----
// ----------------------------------------------------------------------------
// TDS meter channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface tdsm_in_if import tdsm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CODE_W-1:0]        adc_sample;
    logic signed [TEMP_W-1:0] water_temp;
    modport source(output valid, adc_sample, water_temp, input ready);
    modport sink(input valid, adc_sample, water_temp, output ready);
endinterface

interface tdsm_out_if import tdsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TDS_W-1:0]  tds_ppm_q4;
    logic [CODE_W-1:0] median_code;
    modport source(output valid, tds_ppm_q4, median_code, input ready);
    modport sink(input valid, tds_ppm_q4, median_code, output ready);
endinterface

interface tdsm_cfg_if import tdsm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/tds_median_compensated_meter_top.sv -----
// ----------------------------------------------------------------------------
// TDS median compensated meter
// Median-filtered, temperature-compensated dissolved solids measurement.
// ----------------------------------------------------------------------------
// A tick that does not fire the compute timer is taken in the idle state, and the
// meter stays idle. A tick that fires it starts a rank-counting median over the
// sample ring that compares every sample with every other, one compare per cycle,
// followed by a 20-step restoring divider and seven passes through one shared
// multiplier (on saturation the divider steps and the last five passes are
// skipped); no next tick is taken until the result is loaded. The result register
// lets that next tick in while the result still waits on the output channel.
// Register writes are taken in any cycle.
`default_nettype none
module tds_median_compensated_meter_top import tdsm_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdsm_in_if.sink     i_in,
    tdsm_cfg_if.sink    i_cfg,
    tdsm_out_if.source  o_out
);
    localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [AW-1:0] addr_i, addr_j;
    logic in_ready;

    assign i_in.ready = in_ready;

    tdsm_ctrl #(.SAMPLES(SAMPLES), .AW(AW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_addr_i   (addr_i),
        .o_addr_j   (addr_j)
    );

    tdsm_dp #(.SAMPLES(SAMPLES), .AW(AW)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .i_addr_i (addr_i),
        .i_addr_j (addr_j),
        .o_stat   (stat)
    );
endmodule
`default_nettype wire

// ----- hdl/tdsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// TDS meter controller
// Sequences the median sweep, the division and the polynomial steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tdsm_ctrl import tdsm_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF,
    parameter int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_dp_stat      i_stat,
    output t_dp_cmd            o_cmd,
    output logic [AW-1:0]      o_addr_i,
    output logic [AW-1:0]      o_addr_j
);
    localparam logic [AW-1:0] LAST = AW'(SAMPLES - 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_i, n_i, r_j, n_j;
    logic [K_W-1:0] r_k, n_k;
    logic r_pv, n_pv, r_pfirst, n_pfirst, r_plast, n_plast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
            r_plast  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_pv     <= n_pv;
            r_pfirst <= n_pfirst;
            r_plast  <= n_plast;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_pv       = 1'b0;
        n_pfirst   = 1'b0;
        n_plast    = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_addr_i   = r_i;
        o_addr_j   = r_j;
        o_cmd.cmp_en    = r_pv;
        o_cmd.cmp_first = r_pfirst;
        o_cmd.cmp_last  = r_plast;
        o_cmd.div_bit   = r_k;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.tick = i_in_valid;
                n_i = '0;
                n_j = '0;
                if (i_in_valid && i_stat.compute_fire) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_pv     = 1'b1;
                n_pfirst = (r_j == '0);
                n_plast  = (r_j == LAST);
                if (r_j == LAST) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                    if (r_i == LAST) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_MED;
            end
            S_MED: begin
                o_cmd.med_en = 1'b1;
                n_state = S_NUM;
            end
            S_NUM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NUM;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DEN;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_k = K_W'(DIV_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.sat) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_k == '0) begin
                        n_state = S_V2;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            S_V2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_VV;
                n_state = S_V3;
            end
            S_V3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_V2V;
                n_state = S_T3;
            end
            S_T3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_C3;
                n_state = S_T2;
            end
            S_T2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_C2;
                n_state = S_T1;
            end
            S_T1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_C1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `TDSM_ASSERT(a_fire_starts_sweep, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid && i_stat.compute_fire) |=> (r_state == S_SWEEP))
    `TDSM_ASSERT(a_push_returns_idle, i_clk, i_rst_n, (r_state == S_PUSH && !i_stat.out_busy) |=> (r_state == S_IDLE))
    `TDSM_NEVER(a_no_compare_in_idle, i_clk, i_rst_n, r_pv && r_state == S_IDLE)
endmodule
`default_nettype wire

// ----- hdl/tdsm_dp.sv -----
// ----------------------------------------------------------------------------
// TDS meter datapath
// Timers, sample ring, rank counting, divider, multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tdsm_dp import tdsm_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF,
    parameter int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tdsm_in_if.sink       i_in,
    tdsm_cfg_if.sink      i_cfg,
    tdsm_out_if.source    o_out,
    input  wire t_dp_cmd  i_cmd,
    input  wire logic [AW-1:0] i_addr_i,
    input  wire logic [AW-1:0] i_addr_j,
    output t_dp_stat      o_stat
);
    localparam int CW = $clog2(SAMPLES + 1);
    localparam logic [AW-1:0] LAST = AW'(SAMPLES - 1);
    localparam logic [CW-1:0] K_LO = CW'((SAMPLES - 1) / 2);
    localparam logic [CW-1:0] K_HI = CW'(SAMPLES / 2);

    logic [15:0] r_sample_iv, r_compute_iv;
    logic [12:0] r_ref_mv, r_full_scale;
    logic [15:0] r_st, r_ct, st_inc, ct_inc;
    logic s_fire, c_fire;
    logic [AW-1:0] r_widx;
    logic [CODE_W-1:0] r_mem [SAMPLES];
    logic [SAMPLES-1:0] r_vld;
    logic signed [TEMP_W-1:0] r_temp;
    logic [CODE_W-1:0] r_cand, r_cmp, r_lo, r_hi, r_med;
    logic [CW-1:0] r_lt, r_eq, lt_n, eq_n;
    logic [27:0] mul_a;
    logic [25:0] mul_b;
    logic [53:0] prod;
    logic [42:0] r_num, r_rem;
    logic [27:0] r_den;
    logic [DIV_BITS-1:0] r_q;
    logic [23:0] r_v2;
    logic [27:0] r_v3;
    logic [53:0] r_t3, r_t2, r_t1;
    logic signed [55:0] r_sum;
    logic r_sat;
    logic signed [12:0] cden;
    logic cden_pos;
    logic [12:0] fs1;
    logic [15:0] fs5;
    logic [47:0] den_sh;
    logic r_out_valid;
    logic [TDS_W-1:0] r_out_tds;
    logic [CODE_W-1:0] r_out_med;
    logic [TDS_W-1:0] res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_iv  <= SAMPLE_IV_RST;
            r_compute_iv <= COMPUTE_IV_RST;
            r_ref_mv     <= REF_MV_RST;
            r_full_scale <= FULL_SCALE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_SAMPLE_IV:  r_sample_iv  <= i_cfg.data;
                REG_COMPUTE_IV: r_compute_iv <= i_cfg.data;
                REG_REF_MV:     r_ref_mv     <= i_cfg.data[12:0];
                REG_FULL_SCALE: r_full_scale <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    assign st_inc = (r_st != 16'hFFFF) ? r_st + 16'd1 : r_st;
    assign ct_inc = (r_ct != 16'hFFFF) ? r_ct + 16'd1 : r_ct;
    assign s_fire = st_inc > r_sample_iv;
    assign c_fire = ct_inc > r_compute_iv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_ct   <= '0;
            r_widx <= '0;
            r_vld  <= '0;
        end else if (i_cmd.tick) begin
            r_st <= s_fire ? 16'd0 : st_inc;
            r_ct <= c_fire ? 16'd0 : ct_inc;
            if (s_fire) begin
                r_vld[r_widx] <= 1'b1;
                r_widx <= (r_widx == LAST) ? '0 : r_widx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && s_fire) begin
            r_mem[r_widx] <= i_in.adc_sample;
        end
        if (i_cmd.tick) begin
            r_temp <= i_in.water_temp;
        end
        r_cand <= r_vld[i_addr_i] ? r_mem[i_addr_i] : '0;
        r_cmp  <= r_vld[i_addr_j] ? r_mem[i_addr_j] : '0;
    end

    assign lt_n = (i_cmd.cmp_first ? '0 : r_lt) + CW'(r_cmp < r_cand);
    assign eq_n = (i_cmd.cmp_first ? '0 : r_eq) + CW'(r_cmp == r_cand);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_lt <= lt_n;
            r_eq <= eq_n;
            if (i_cmd.cmp_last) begin
                if (K_LO >= lt_n && K_LO < lt_n + eq_n) begin
                    r_lo <= r_cand;
                end
                if (K_HI >= lt_n && K_HI < lt_n + eq_n) begin
                    r_hi <= r_cand;
                end
            end
        end
        if (i_cmd.med_en) begin
            r_med <= CODE_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        end
    end

    assign cden     = $signed({r_temp[TEMP_W-1], r_temp}) + TEMP_OFFSET;
    assign cden_pos = !cden[12] && (cden != '0);
    assign fs1      = (r_full_scale == '0) ? 13'd1 : r_full_scale;
    assign fs5      = {3'b0, fs1} + {1'b0, fs1, 2'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_NUM: begin mul_a = 28'(r_med);  mul_b = 26'(r_ref_mv); end
            MUL_DEN: begin mul_a = 28'(fs5);    mul_b = 26'(cden[11:0]); end
            MUL_VV:  begin mul_a = 28'(r_q);    mul_b = 26'(r_q); end
            MUL_V2V: begin mul_a = 28'(r_v2);   mul_b = 26'(r_q); end
            MUL_C3:  begin mul_a = r_v3;        mul_b = C3_Q16; end
            MUL_C2:  begin mul_a = 28'(r_v2);   mul_b = C2_Q16; end
            MUL_C1:  begin mul_a = 28'(r_q);    mul_b = C1_Q16; end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign den_sh = {20'b0, r_den} << i_cmd.div_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_NUM: r_num <= {prod[24:0], 18'b0};
                MUL_DEN: r_den <= prod[27:0];
                MUL_VV:  r_v2  <= prod[39:16];
                MUL_V2V: r_v3  <= prod[43:16];
                MUL_C3:  r_t3  <= prod;
                MUL_C2:  r_t2  <= prod;
                MUL_C1:  r_t1  <= prod;
                default: ;
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem <= r_num;
            r_q   <= '0;
            r_sat <= !cden_pos || ({5'b0, r_num} >= {r_den, 20'b0});
        end else if (i_cmd.div_step) begin
            if ({5'b0, r_rem} >= den_sh) begin
                r_rem <= 43'({5'b0, r_rem} - den_sh);
                r_q[i_cmd.div_bit] <= 1'b1;
            end
        end
        if (i_cmd.sum_en) begin
            r_sum <= $signed({2'b0, r_t3}) - $signed({2'b0, r_t2})
                   + $signed({2'b0, r_t1});
        end
    end

    always_comb begin
        if (r_sat) begin
            res = TDS_MAX;
        end else if (r_sum[55]) begin
            res = '0;
        end else if (r_sum[54:49] != '0) begin
            res = TDS_MAX;
        end else begin
            res = r_sum[48:29];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tds <= res;
            r_out_med <= r_med;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tds_ppm_q4  = r_out_tds;
    assign o_out.median_code = r_out_med;

    assign o_stat.compute_fire = c_fire;
    assign o_stat.sat          = r_sat;
    assign o_stat.out_busy     = r_out_valid && !o_out.ready;

    `TDSM_ASSERT(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(i_cmd.load_out))
    `TDSM_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_tds) && $stable(r_out_med)))
    `TDSM_NEVER(a_widx_range, i_clk, i_rst_n, r_widx > LAST)
endmodule
`default_nettype wire

// ----- tb/tb_tds_median_compensated_meter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TDS median compensated meter testbench
// Drives ticks and register writes into the meter, keeps its own
// model of the sample ring, the timers and the fixed-point compensation, and
// compares every reading that comes out against the predicted one.
// ----------------------------------------------------------------------------
module tb_tds_median_compensated_meter_top;
    import tdsm_pkg::*;

    localparam int RING_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 50;

    typedef struct {
        logic [TDS_W-1:0]  tds_ppm_q4;
        logic [CODE_W-1:0] median_code;
    } t_meter_reading;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tdsm_in_if  tick_if();
    tdsm_cfg_if cfg_if();
    tdsm_out_if reading_if();

    tds_median_compensated_meter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .i_cfg   (cfg_if),
        .o_out   (reading_if)
    );

    // Model state and configuration.
    logic [15:0]       sample_iv;
    logic [15:0]       compute_iv;
    logic [12:0]       ref_mv;
    logic [12:0]       full_scale;
    logic [CODE_W-1:0] ring [RING_DEPTH];
    int unsigned       ring_wr;
    int unsigned       sample_timer;
    int unsigned       compute_timer;

    t_meter_reading pending_readings[$];
    int             errors = 0;
    int             cycles = 0;
    bit             no_idle = 1'b0;
    int             ready_hold;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // After each transaction the result side may drop ready at random, except in the no-idle phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reading_if.ready <= 1'b0;
            ready_hold <= 0;
        end else if (reading_if.ready && reading_if.valid) begin
            int hold_n;
            hold_n = no_idle ? 0 : $urandom_range(0, 10);
            reading_if.ready <= (hold_n == 0);
            ready_hold <= hold_n;
        end else if (!reading_if.ready) begin
            if (ready_hold <= 1)
                reading_if.ready <= 1'b1;
            if (ready_hold > 0)
                ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && reading_if.valid && reading_if.ready) begin
            t_meter_reading exp_r;
            if (pending_readings.size() == 0) begin
                $error("unexpected reading tds_ppm_q4=%0d median_code=%0d",
                       reading_if.tds_ppm_q4, reading_if.median_code);
                errors++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (reading_if.tds_ppm_q4 !== exp_r.tds_ppm_q4) begin
                    $error("tds_ppm_q4 expected %0d actual %0d",
                           exp_r.tds_ppm_q4, reading_if.tds_ppm_q4);
                    errors++;
                end
                if (reading_if.median_code !== exp_r.median_code) begin
                    $error("median_code expected %0d actual %0d",
                           exp_r.median_code, reading_if.median_code);
                    errors++;
                end
            end
        end
    end

    function automatic logic [CODE_W-1:0] ring_median();
        logic [CODE_W-1:0] t [RING_DEPTH];
        logic [CODE_W-1:0] x;
        int j;
        for (int i = 0; i < RING_DEPTH; i++) begin
            x = ring[i];
            j = i;
            while (j > 0 && t[j-1] > x) begin
                t[j] = t[j-1];
                j--;
            end
            t[j] = x;
        end
        return CODE_W'(({1'b0, t[RING_DEPTH/2]} + {1'b0, t[RING_DEPTH/2-1]}) >> 1);
    endfunction

    function automatic logic [TDS_W-1:0] compensated_tds(logic [CODE_W-1:0] med,
                                                         logic signed [TEMP_W-1:0] temp);
        int cden;
        longint unsigned fs, num, den, v, v2, v3;
        longint sum, r;
        cden = int'(temp) + 400;
        if (cden <= 0)
            return TDS_MAX;
        fs = (full_scale == 0) ? 64'd1 : 64'(full_scale);
        num = (64'(med) * 64'(ref_mv)) << 18;
        den = fs * 64'd5 * 64'(cden);
        v = num / den;
        if (v >= (64'd16 << 16))
            return TDS_MAX;
        v2 = (v * v) >> 16;
        v3 = (v2 * v) >> 16;
        sum = longint'(64'(C3_Q16)) * longint'(v3) - longint'(64'(C2_Q16)) * longint'(v2)
            + longint'(64'(C1_Q16)) * longint'(v);
        if (sum < 0)
            return '0;
        r = sum >>> 29;
        if (r > longint'(64'(TDS_MAX)))
            return TDS_MAX;
        return r[TDS_W-1:0];
    endfunction

    task automatic advance_meter(logic [CODE_W-1:0] code, logic signed [TEMP_W-1:0] temp);
        t_meter_reading rd;
        if (sample_timer < 65535)
            sample_timer++;
        if (sample_timer > sample_iv) begin
            sample_timer = 0;
            ring[ring_wr] = code;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
        end
        if (compute_timer < 65535)
            compute_timer++;
        if (compute_timer > compute_iv) begin
            compute_timer = 0;
            rd.median_code = ring_median();
            rd.tds_ppm_q4 = compensated_tds(rd.median_code, temp);
            pending_readings.push_back(rd);
        end
    endtask

    task automatic send_tick(logic [CODE_W-1:0] code, logic signed [TEMP_W-1:0] temp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.adc_sample <= code;
        tick_if.water_temp <= temp;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        advance_meter(code, temp);
    endtask

    task automatic wait_drained();
        tick_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_SAMPLE_IV:  sample_iv = value;
            REG_COMPUTE_IV: compute_iv = value;
            REG_REF_MV:     ref_mv = value[12:0];
            REG_FULL_SCALE: full_scale = value[12:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic signed [TEMP_W-1:0] temps [10] = '{-12'sd2048, -12'sd401, -12'sd400,
            -12'sd399, -12'sd160, 12'sd0, 12'sd400, 12'sd1600, 12'sd2047, 12'sd1};
        write_reg(REG_SAMPLE_IV, 16'd0);
        write_reg(REG_COMPUTE_IV, 16'd0);
        for (int i = 0; i < 10; i++)
            send_tick((i % 2) ? 12'hFFF : 12'h000, temps[i]);
        send_tick(12'hAAA, 12'sd400);
        send_tick(12'h555, 12'sd400);
        wait_drained();
    endtask

    task automatic test_large_voltage();
        write_reg(REG_REF_MV, 16'hFFFF);
        write_reg(REG_FULL_SCALE, 16'd0);
        send_tick(12'hFFF, 12'sd400);
        send_tick(12'hFFF, 12'sd400);
        wait_drained();
        write_reg(REG_FULL_SCALE, 16'd4096);
        write_reg(REG_REF_MV, 16'd1);
        send_tick(12'hFFF, 12'sd1600);
        send_tick(12'd7, 12'sd1600);
        wait_drained();
    endtask

    task automatic test_timer_limit();
        write_reg(REG_SAMPLE_IV, 16'hFFFF);
        write_reg(REG_COMPUTE_IV, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_tick(12'($urandom), 12'sd300);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [CODE_W-1:0]        code;
        logic signed [TEMP_W-1:0] temp;
        logic [12:0] refs [3] = '{13'd5000, 13'd3300, 13'd8191};
        logic [12:0] scales [3] = '{13'd1024, 13'd4096, 13'd1};
        for (int p = 0; p < 5; p++) begin
            no_idle = (p == 2);
            write_reg(REG_SAMPLE_IV, 16'($urandom_range(0, 3)));
            write_reg(REG_COMPUTE_IV, 16'($urandom_range(0, 4)));
            write_reg(REG_REF_MV, (p < 3) ? 16'(refs[p]) : 16'($urandom_range(1, 5000)));
            write_reg(REG_FULL_SCALE,
                      (p < 3) ? 16'(scales[p]) : 16'($urandom_range(1, 4096)));
            for (int i = 0; i < 53; i++) begin
                case ($urandom_range(0, 9))
                    0:       code = 12'hFFF;
                    1:       code = 12'h000;
                    default: code = 12'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0)
                    temp = 12'($urandom);
                else
                    temp = 12'(signed'($urandom_range(0, 1760)) - 160);
                send_tick(code, temp);
                if (i == 26 && p == 1)
                    wait_drained();
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        tick_if.valid <= 1'b0;
        tick_if.adc_sample <= '0;
        tick_if.water_temp <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_SAMPLE_IV;
        cfg_if.data <= '0;
        sample_iv = SAMPLE_IV_RST;
        compute_iv = COMPUTE_IV_RST;
        ref_mv = REF_MV_RST;
        full_scale = FULL_SCALE_RST;
        foreach (ring[i]) ring[i] = '0;
        ring_wr = 0;
        sample_timer = 0;
        compute_timer = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_large_voltage();
        test_timer_limit();
        test_random_phases();

        if (pending_readings.size() != 0) begin
            $error("%0d readings never arrived", pending_readings.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
